@@ src/ps2_mouse_packet_event_queue_macros.svh @@
// ----------------------------------------------------------------------------
// PS/2 mouse event queue assertion macros
// Shared assertion forms for the event queue RTL.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_EVENT_QUEUE_MACROS_SVH
`define PS2_MOUSE_PACKET_EVENT_QUEUE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PS2MQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ps2mq: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define PS2MQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ps2mq: next-cycle check failed");

`endif

@@ src/ps2mq_pkg.sv @@
// ----------------------------------------------------------------------------
// PS/2 mouse event queue package
// Payload types, codes and small helper functions shared by the RTL.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ps2mq_pkg;

   // Request codes; bit 1 set means pop
   localparam logic [1:0] REQ_FEED    = 2'd0;
   localparam logic [1:0] REQ_POST    = 2'd1;
   localparam int         REQ_POP_BIT = 1;

   // Result status codes
   localparam logic [2:0] STAT_STORED   = 3'd0;
   localparam logic [2:0] STAT_IGNORED  = 3'd1;
   localparam logic [2:0] STAT_RESYNC   = 3'd2;
   localparam logic [2:0] STAT_OVERFLOW = 3'd3;
   localparam logic [2:0] STAT_QUEUED   = 3'd4;
   localparam logic [2:0] STAT_FULL     = 3'd5;
   localparam logic [2:0] STAT_POPPED   = 3'd6;
   localparam logic [2:0] STAT_EMPTY    = 3'd7;

   // Configuration register indexes
   localparam int         CSR_IDX_W  = 1;
   localparam logic [0:0] CSR_ENABLE = 1'd0;
   localparam logic [0:0] CSR_FLIP_Y = 1'd1;

   // Packet byte positions
   localparam logic [1:0] BYTE_FLAGS = 2'd0;
   localparam logic [1:0] BYTE_X     = 2'd1;
   localparam logic [1:0] BYTE_Y     = 2'd2;

   // Flag byte bits
   localparam int FLAG_SYNC_BIT = 3;
   localparam int FLAG_XSGN_BIT = 4;
   localparam int FLAG_YSGN_BIT = 5;
   localparam int FLAG_XOVF_BIT = 6;
   localparam int FLAG_YOVF_BIT = 7;

   localparam int MOT_W      = 17;
   localparam int MOTION_MAX = 127;
   localparam int WORD_W     = 32;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [7:0]         data_byte;
      logic signed [15:0] post_dx;
      logic signed [15:0] post_dy;
      logic [2:0]         post_buttons;
   } req_item_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [WORD_W-1:0] event_word;
      logic [11:0]       pos_x;
      logic [11:0]       pos_y;
   } rsp_item_type;

   typedef struct packed {
      logic              push;
      logic              pop;
      logic [WORD_W-1:0] wdata;
   } ring_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } ring_stat_type;

   function automatic logic signed [7:0] clamp_motion(input logic signed [MOT_W-1:0] v);
      if (v > MOTION_MAX) begin
         return 8'(MOTION_MAX);
      end else if (v < -MOTION_MAX) begin
         return 8'(-MOTION_MAX);
      end else begin
         return v[7:0];
      end
   endfunction

   // bit31 valid, 23:16 dy, 15:8 dx, 2:0 buttons
   function automatic logic [WORD_W-1:0] pack_event(input logic [2:0] buttons,
                                                    input logic [7:0] dx,
                                                    input logic [7:0] dy);
      return {1'b1, 7'd0, dy, dx, 5'd0, buttons};
   endfunction

endpackage

@@ src/ps2mq_ring.sv @@
// ----------------------------------------------------------------------------
// PS/2 mouse event ring
// Single-port-write event memory with head and tail pointers and a
// registered read of the oldest entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ps2_mouse_packet_event_queue_macros.svh"

module ps2mq_ring #(
   parameter int RING_DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ps2mq_pkg::ring_cmd_type       cmd,
   output ps2mq_pkg::ring_stat_type      stat,
   output logic [ps2mq_pkg::WORD_W-1:0]  rd_data
);

   localparam int IDX_W = $clog2(RING_DEPTH);

   logic [ps2mq_pkg::WORD_W-1:0] mem [RING_DEPTH];
   logic [ps2mq_pkg::WORD_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]             head_ff, head_in;
   logic [IDX_W-1:0]             tail_ff, tail_in;
   logic [IDX_W-1:0]             head_nxt;

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
      return (i == IDX_W'(RING_DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   assign head_nxt   = ring_next(head_ff);
   assign stat.empty = (head_ff == tail_ff);
   assign stat.full  = (head_nxt == tail_ff);
   assign head_in    = cmd.push ? head_nxt : head_ff;
   assign tail_in    = cmd.pop ? ring_next(tail_ff) : tail_ff;
   assign rd_data    = rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   // Write at head, read the oldest entry at tail
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[head_ff] <= cmd.wdata;
      end
      if (cmd.pop) begin
         rd_data_ff <= mem[tail_ff];
      end
   end

   `PS2MQ_ASSERT_IMPLY(a_no_push_full, clock, reset, cmd.push, !stat.full)
   `PS2MQ_ASSERT_IMPLY(a_no_pop_empty, clock, reset, cmd.pop, !stat.empty && !cmd.push)

endmodule

@@ src/ps2_mouse_packet_event_queue.sv @@
// ----------------------------------------------------------------------------
// PS/2 mouse packet event queue
// Assembles 3-byte PS/2 mouse packets, tracks a saturating cursor and keeps
// decoded or posted events in a ring that the host pops.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                              | Moves
//  --------+------------------------------------+-------------------------------
//  request | req_valid, req_ready, req_data     | feed byte, post event or pop
//  result  | rsp_valid, rsp_ready, rsp_data     | status, event word, cursor
//  config  | csr_wr_en, csr_index, csr_wr_data  | enable, flip_y (write only)
//
//  One request transfer per clock, sustained while results drain. Each result
//  passes the middle stage, where the synchronous ring read completes, and then
//  the output register; the middle stage is there for the ring memory read port.
//  Reset (synchronous) clears the byte index, pointers, cursor and pipeline
//  valids; ring contents are not cleared and need no clearing pass.
//  A stalled result holds the output register; the middle stage keeps one more
//  result, so the request side stalls only when both are full and rsp_ready
//  is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ps2_mouse_packet_event_queue_macros.svh"

module ps2_mouse_packet_event_queue #(
   parameter int RING_DEPTH = 64,
   parameter int POS_LIMIT  = 4095
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  ps2mq_pkg::req_item_type         req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output ps2mq_pkg::rsp_item_type         rsp_data,
   input  logic                            csr_wr_en,
   input  logic [ps2mq_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic                            csr_wr_data
);

   localparam int POS_W = $clog2(POS_LIMIT + 1);

   // Configuration
   logic enable_ff;
   logic flip_y_ff;

   // Packet assembly and cursor state
   logic [1:0]       byte_idx_ff, byte_idx_in;
   logic [7:0]       flag_ff, flag_in;
   logic [7:0]       xbyte_ff, xbyte_in;
   logic [POS_W-1:0] cur_x_ff, cur_x_in;
   logic [POS_W-1:0] cur_y_ff, cur_y_in;

   // Middle stage (waits on ring read data)
   logic                         s1_valid_ff;
   logic [2:0]                   s1_status_ff, status_in;
   logic [ps2mq_pkg::WORD_W-1:0] s1_word_ff, word_in;
   logic                         s1_pop_ff, pop_in;
   logic [11:0]                  s1_pos_x_ff;
   logic [11:0]                  s1_pos_y_ff;

   // Output register
   logic                    rsp_valid_ff;
   ps2mq_pkg::rsp_item_type rsp_data_ff;
   logic                    rsp_has_word;

   // Handshake
   logic req_fire;
   logic s1_adv;

   // Decode
   logic                         is_pop;
   logic                         ev_do;
   logic                         pkt_ovf;
   logic signed [ps2mq_pkg::MOT_W-1:0] raw_dx;
   logic signed [ps2mq_pkg::MOT_W-1:0] raw_dy;
   logic signed [ps2mq_pkg::MOT_W-1:0] pkt_dy;
   logic signed [7:0]            dx_c;
   logic signed [7:0]            dy_c;
   logic [2:0]                   ev_buttons;
   logic [ps2mq_pkg::WORD_W-1:0] ev_word;

   // Ring
   ps2mq_pkg::ring_cmd_type      ring_cmd;
   ps2mq_pkg::ring_stat_type     ring_stat;
   logic [ps2mq_pkg::WORD_W-1:0] ring_rd_data;

   function automatic logic [POS_W-1:0] sat_pos(input logic [POS_W-1:0] cur,
                                                input logic signed [7:0] d);
      logic signed [POS_W+1:0] sum;
      sum = $signed({2'b00, cur}) + (POS_W+2)'(d);
      if (sum < 0) begin
         return '0;
      end else if (sum > $signed((POS_W+2)'(POS_LIMIT))) begin
         return POS_W'(POS_LIMIT);
      end else begin
         return sum[POS_W-1:0];
      end
   endfunction

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         flip_y_ff <= 1'b1;
      end else if (csr_wr_en) begin
         case (csr_index)
            ps2mq_pkg::CSR_ENABLE: enable_ff <= csr_wr_data;
            ps2mq_pkg::CSR_FLIP_Y: flip_y_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Advance the middle stage when the output register is free or drains;
   // take a new request whenever the middle stage empties or advances.
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_fire  = req_valid && req_ready;

   // Motion: sign-extend 9-bit packet deltas, negate dy unless told not to
   assign is_pop  = req_data.req_type[ps2mq_pkg::REQ_POP_BIT];
   assign pkt_ovf = flag_ff[ps2mq_pkg::FLAG_XOVF_BIT] || flag_ff[ps2mq_pkg::FLAG_YOVF_BIT];
   assign pkt_dy  = $signed({{8{flag_ff[ps2mq_pkg::FLAG_YSGN_BIT]}},
                             flag_ff[ps2mq_pkg::FLAG_YSGN_BIT], req_data.data_byte});

   always_comb begin
      if (req_data.req_type == ps2mq_pkg::REQ_POST) begin
         raw_dx     = $signed({req_data.post_dx[15], req_data.post_dx});
         raw_dy     = $signed({req_data.post_dy[15], req_data.post_dy});
         ev_buttons = req_data.post_buttons;
      end else begin
         raw_dx     = $signed({{8{flag_ff[ps2mq_pkg::FLAG_XSGN_BIT]}},
                               flag_ff[ps2mq_pkg::FLAG_XSGN_BIT], xbyte_ff});
         raw_dy     = flip_y_ff ? -pkt_dy : pkt_dy;
         ev_buttons = flag_ff[2:0];
      end
   end

   assign dx_c    = ps2mq_pkg::clamp_motion(raw_dx);
   assign dy_c    = ps2mq_pkg::clamp_motion(raw_dy);
   assign ev_word = ps2mq_pkg::pack_event(ev_buttons, dx_c, dy_c);

   // Request decode: next state, status and ring command
   always_comb begin
      byte_idx_in   = byte_idx_ff;
      flag_in       = flag_ff;
      xbyte_in      = xbyte_ff;
      status_in     = ps2mq_pkg::STAT_STORED;
      word_in       = '0;
      pop_in        = 1'b0;
      ev_do         = 1'b0;
      ring_cmd.push = 1'b0;
      ring_cmd.pop  = 1'b0;
      ring_cmd.wdata = ev_word;

      if (is_pop) begin
         if (ring_stat.empty) begin
            status_in = ps2mq_pkg::STAT_EMPTY;
         end else begin
            status_in    = ps2mq_pkg::STAT_POPPED;
            pop_in       = 1'b1;
            ring_cmd.pop = req_fire;
         end
      end else if (req_data.req_type == ps2mq_pkg::REQ_POST) begin
         ev_do = 1'b1;
      end else if (!enable_ff) begin
         status_in = ps2mq_pkg::STAT_IGNORED;
      end else begin
         case (byte_idx_ff)
            ps2mq_pkg::BYTE_FLAGS: begin
               // Drop a first byte without the sync bit to resync
               if (!req_data.data_byte[ps2mq_pkg::FLAG_SYNC_BIT]) begin
                  status_in = ps2mq_pkg::STAT_RESYNC;
               end else begin
                  flag_in     = req_data.data_byte;
                  byte_idx_in = ps2mq_pkg::BYTE_X;
               end
            end
            ps2mq_pkg::BYTE_X: begin
               xbyte_in    = req_data.data_byte;
               byte_idx_in = ps2mq_pkg::BYTE_Y;
            end
            default: begin
               byte_idx_in = ps2mq_pkg::BYTE_FLAGS;
               if (pkt_ovf) begin
                  status_in = ps2mq_pkg::STAT_OVERFLOW;
               end else begin
                  ev_do = 1'b1;
               end
            end
         endcase
      end

      if (ev_do) begin
         if (ring_stat.full) begin
            status_in = ps2mq_pkg::STAT_FULL;
         end else begin
            status_in     = ps2mq_pkg::STAT_QUEUED;
            word_in       = ev_word;
            ring_cmd.push = req_fire;
         end
      end
   end

   // Cursor moves on every event, queued or dropped for a full ring
   assign cur_x_in = ev_do ? sat_pos(cur_x_ff, dx_c) : cur_x_ff;
   assign cur_y_in = ev_do ? sat_pos(cur_y_ff, dy_c) : cur_y_ff;

   ps2mq_ring #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .cmd     (ring_cmd),
      .stat    (ring_stat),
      .rd_data (ring_rd_data)
   );

   // Block state: update on each request transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_idx_ff <= ps2mq_pkg::BYTE_FLAGS;
         flag_ff     <= '0;
         xbyte_ff    <= '0;
         cur_x_ff    <= '0;
         cur_y_ff    <= '0;
      end else if (req_fire) begin
         byte_idx_ff <= byte_idx_in;
         flag_ff     <= flag_in;
         xbyte_ff    <= xbyte_in;
         cur_x_ff    <= cur_x_in;
         cur_y_ff    <= cur_y_in;
      end
   end

   // Middle stage: hold while the output register is stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (req_fire) begin
         s1_status_ff <= status_in;
         s1_word_ff   <= word_in;
         s1_pop_ff    <= pop_in;
         s1_pos_x_ff  <= 12'(cur_x_in);
         s1_pos_y_ff  <= 12'(cur_y_in);
      end
   end

   // Output register: merge ring read data for pops
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_ready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (s1_adv) begin
         rsp_data_ff.status     <= s1_status_ff;
         rsp_data_ff.event_word <= s1_pop_ff ? ring_rd_data : s1_word_ff;
         rsp_data_ff.pos_x      <= s1_pos_x_ff;
         rsp_data_ff.pos_y      <= s1_pos_y_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Only queued and popped results carry a word
   assign rsp_has_word = rsp_data_ff.status inside {ps2mq_pkg::STAT_QUEUED,
                                                    ps2mq_pkg::STAT_POPPED};

   `PS2MQ_ASSERT_IMPLY(a_word_zero, clock, reset, rsp_valid_ff && !rsp_has_word, rsp_data_ff.event_word == '0)
   `PS2MQ_ASSERT_IMPLY(a_pop_word_valid, clock, reset, rsp_valid_ff && rsp_data_ff.status == ps2mq_pkg::STAT_POPPED, rsp_data_ff.event_word[31])
   `PS2MQ_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && rsp_valid_ff && !rsp_ready, s1_valid_ff && $stable(s1_status_ff))

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// PS/2 mouse packet event queue testbench
// Drives feed, post and pop requests through the valid/ready request channel
// and checks every result against a cycle-free predictor. The predictor keeps
// its own packet assembler, saturating cursor and event ring. Phases change
// enable and flip_y while the block is idle. Sender and receiver idling vary
// between phases, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   // Pop codes; bit 1 of the request type selects pop, so code three pops too
   localparam logic [1:0] REQ_POP     = 2'd2;
   localparam logic [1:0] REQ_POP_ODD = 2'd3;

   localparam int RING_SLOTS     = 64;
   localparam int CURSOR_MAX     = 4095;
   localparam int HOLD_CYCLES    = 300;
   localparam int IDLE_SPIN_MAX  = 20000;
   localparam int TAIL_CYCLES    = 10;

   // Clock, reset and block ports; every input starts at a known value
   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_valid   = 1'b0;
   logic                    req_ready;
   ps2mq_pkg::req_item_type req_data    = '0;
   logic                    rsp_valid;
   logic                    rsp_ready   = 1'b0;
   ps2mq_pkg::rsp_item_type rsp_data;
   logic                    csr_wr_en   = 1'b0;
   logic [ps2mq_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic                    csr_wr_data = 1'b0;

   // Traffic bookkeeping
   ps2mq_pkg::req_item_type req_pend_q[$];
   ps2mq_pkg::rsp_item_type rsp_expect_q[$];
   ps2mq_pkg::rsp_item_type exp_rsp;
   int           queued_total = 0;
   int           accepted_cnt = 0;
   int           err_count    = 0;
   int           stat_seen[8] = '{default: 0};
   logic         req_xfer     = 1'b0;
   int           send_idle_pct = 0;
   int           rsp_idle_pct  = 0;
   bit           pressure_start = 1'b0;
   logic         pressure_hold  = 1'b0;

   // Predictor state: configuration, packet assembler, ring and cursor
   logic         cfg_enable = 1'b0;
   logic         cfg_flip_y = 1'b1;
   logic [1:0]   pkt_phase  = ps2mq_pkg::BYTE_FLAGS;
   logic [7:0]   pkt_flags  = '0;
   logic [7:0]   pkt_x      = '0;
   logic [31:0]  ring_model[RING_SLOTS];
   int           ring_wr    = 0;
   int           ring_rd    = 0;
   int           cur_x      = 0;
   int           cur_y      = 0;

   ps2_mouse_packet_event_queue DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // Limit one motion component to +/-127
   function automatic int clip_motion(input int v);
      if (v > 127) begin
         return 127;
      end else if (v < -127) begin
         return -127;
      end
      return v;
   endfunction

   // Saturate a cursor coordinate to the screen range
   function automatic int clip_pos(input int v);
      if (v < 0) begin
         return 0;
      end else if (v > CURSOR_MAX) begin
         return CURSOR_MAX;
      end
      return v;
   endfunction

   // Move the cursor and push the event word; the cursor moves even when the
   // ring turns the event away
   function automatic logic [2:0] queue_event(input int dx, input int dy,
                                              input logic [2:0] btn,
                                              output logic [31:0] word);
      int          mx;
      int          my;
      int          nxt;
      logic [31:0] ev;
      mx = clip_motion(dx);
      my = clip_motion(dy);
      cur_x = clip_pos(cur_x + mx);
      cur_y = clip_pos(cur_y + my);
      ev = {1'b1, 7'd0, my[7:0], mx[7:0], 5'd0, btn};
      nxt = (ring_wr + 1) % RING_SLOTS;
      if (nxt == ring_rd) begin
         word = '0;
         return ps2mq_pkg::STAT_FULL;
      end
      ring_model[ring_wr] = ev;
      ring_wr = nxt;
      word = ev;
      return ps2mq_pkg::STAT_QUEUED;
   endfunction

   // Work out the one result that an accepted request causes
   function automatic ps2mq_pkg::rsp_item_type decode_request(
         input ps2mq_pkg::req_item_type r);
      ps2mq_pkg::rsp_item_type o;
      logic [31:0]  w;
      int           dx;
      int           dy;
      w = '0;
      if (r.req_type[ps2mq_pkg::REQ_POP_BIT]) begin
         if (ring_rd == ring_wr) begin
            o.status = ps2mq_pkg::STAT_EMPTY;
         end else begin
            w = ring_model[ring_rd];
            ring_rd = (ring_rd + 1) % RING_SLOTS;
            o.status = ps2mq_pkg::STAT_POPPED;
         end
      end else if (r.req_type == ps2mq_pkg::REQ_POST) begin
         // posts bypass the enable gate and flip_y
         o.status = queue_event(r.post_dx, r.post_dy, r.post_buttons, w);
      end else if (!cfg_enable) begin
         o.status = ps2mq_pkg::STAT_IGNORED;
      end else if (pkt_phase == ps2mq_pkg::BYTE_FLAGS) begin
         if (!r.data_byte[ps2mq_pkg::FLAG_SYNC_BIT]) begin
            o.status = ps2mq_pkg::STAT_RESYNC;
         end else begin
            pkt_flags = r.data_byte;
            pkt_phase = ps2mq_pkg::BYTE_X;
            o.status = ps2mq_pkg::STAT_STORED;
         end
      end else if (pkt_phase == ps2mq_pkg::BYTE_X) begin
         pkt_x = r.data_byte;
         pkt_phase = ps2mq_pkg::BYTE_Y;
         o.status = ps2mq_pkg::STAT_STORED;
      end else begin
         pkt_phase = ps2mq_pkg::BYTE_FLAGS;
         if (pkt_flags[ps2mq_pkg::FLAG_XOVF_BIT] || pkt_flags[ps2mq_pkg::FLAG_YOVF_BIT]) begin
            o.status = ps2mq_pkg::STAT_OVERFLOW;
         end else begin
            // 9-bit two's complement motion from byte plus sign flag
            dx = int'(pkt_x) - (pkt_flags[ps2mq_pkg::FLAG_XSGN_BIT] ? 256 : 0);
            dy = int'(r.data_byte) - (pkt_flags[ps2mq_pkg::FLAG_YSGN_BIT] ? 256 : 0);
            if (cfg_flip_y) begin
               dy = -dy;
            end
            o.status = queue_event(dx, dy, pkt_flags[2:0], w);
         end
      end
      o.event_word = w;
      o.pos_x = cur_x[11:0];
      o.pos_y = cur_y[11:0];
      return o;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Fill every field at random so unused fields toggle too, then set the kind
   function automatic ps2mq_pkg::req_item_type make_req(input logic [1:0] kind);
      logic [63:0]             raw;
      ps2mq_pkg::req_item_type it;
      raw = {$urandom, $urandom};
      it = raw[$bits(ps2mq_pkg::req_item_type)-1:0];
      it.req_type = kind;
      return it;
   endfunction

   task automatic queue_req(input ps2mq_pkg::req_item_type it);
      req_pend_q.push_back(it);
      queued_total++;
   endtask

   task automatic feed_item(input logic [7:0] b);
      ps2mq_pkg::req_item_type it;
      it = make_req(ps2mq_pkg::REQ_FEED);
      it.data_byte = b;
      queue_req(it);
   endtask

   task automatic post_item(input int dx, input int dy, input logic [2:0] btn);
      ps2mq_pkg::req_item_type it;
      it = make_req(ps2mq_pkg::REQ_POST);
      it.post_dx = dx[15:0];
      it.post_dy = dy[15:0];
      it.post_buttons = btn;
      queue_req(it);
   endtask

   task automatic pop_item(input logic [1:0] code);
      queue_req(make_req(code));
   endtask

   // Mostly well-formed packets with random content, mixed with posts, pops
   // and stray bytes that knock the assembler out of step
   task automatic gen_traffic(input int n);
      int         added;
      int         pick;
      logic [7:0] flags;
      added = 0;
      while (added < n) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            flags = 8'($urandom);
            flags[ps2mq_pkg::FLAG_SYNC_BIT] = 1'b1;
            if ($urandom_range(99) < 85) begin
               flags[ps2mq_pkg::FLAG_XOVF_BIT] = 1'b0;
               flags[ps2mq_pkg::FLAG_YOVF_BIT] = 1'b0;
            end
            feed_item(flags);
            feed_item(8'($urandom));
            feed_item(8'($urandom));
            added += 3;
         end else if (pick < 65) begin
            if ($urandom_range(1) == 1) begin
               post_item(int'($urandom), int'($urandom), 3'($urandom));
            end else begin
               post_item(int'($urandom_range(400)) - 200,
                         int'($urandom_range(400)) - 200, 3'($urandom));
            end
            added++;
         end else if (pick < 85) begin
            pop_item($urandom_range(1) == 1 ? REQ_POP_ODD : REQ_POP);
            added++;
         end else begin
            feed_item(8'($urandom));
            added++;
         end
      end
   endtask

   // Called at a falling edge; returns at a falling edge once every queued
   // request has been transferred and every result has come back
   task automatic wait_idle();
      int spins;
      spins = 0;
      @(negedge clock);
      while ((accepted_cnt != queued_total || rsp_expect_q.size() != 0)
             && spins < IDLE_SPIN_MAX) begin
         @(negedge clock);
         spins++;
      end
   endtask

   // Write one register at a falling edge, then drop the enable in the following cycle
   task automatic write_csr(input logic [ps2mq_pkg::CSR_IDX_W-1:0] idx, input logic val);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      if (idx == ps2mq_pkg::CSR_ENABLE) begin
         cfg_enable = val;
      end else begin
         cfg_flip_y = val;
      end
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // Set idling for the next phase at a rising edge, away from the driver
   task automatic start_phase(input int send_pct, input int recv_pct);
      @(posedge clock);
      send_idle_pct = send_pct;
      rsp_idle_pct  = recv_pct;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                  input logic [31:0] got_v);
      $display("MISMATCH %s: expected %h, got %h (result %0d)",
               what, exp_v, got_v, accepted_cnt);
      err_count++;
   endtask

   // ------------------------------------------------------------------------
   // Request driver: change inputs on the falling edge
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_xfer) begin
         // hold valid and payload until the transfer happens
      end else if (req_pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
         req_valid <= 1'b1;
         req_data  <= req_pend_q.pop_front();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Result ready: random idling, forced low during the long hold-off
   always @(negedge clock) begin
      rsp_ready <= !pressure_hold && ($urandom_range(99) >= rsp_idle_pct);
   end

   // Long receiver hold-off, counted here; the sender keeps offering items
   // so the block's output stages fill and req_ready drops
   initial begin
      wait (pressure_start);
      @(negedge clock);
      pressure_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      pressure_hold <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // Monitor: sample both channels on the rising edge
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_xfer <= 1'b0;
      end else begin
         req_xfer <= req_valid && req_ready;
         // predict in transfer order
         if (req_valid && req_ready) begin
            rsp_expect_q.push_back(decode_request(req_data));
            accepted_cnt++;
         end
         if (rsp_valid && rsp_ready) begin
            if (rsp_expect_q.size() == 0) begin
               report_mismatch("result with nothing expected", '0, rsp_data.event_word);
            end else begin
               exp_rsp = rsp_expect_q.pop_front();
               stat_seen[exp_rsp.status]++;
               if (rsp_data.status !== exp_rsp.status) begin
                  report_mismatch("status", 32'(exp_rsp.status), 32'(rsp_data.status));
               end
               if (rsp_data.event_word !== exp_rsp.event_word) begin
                  report_mismatch("event_word", exp_rsp.event_word, rsp_data.event_word);
               end
               if (rsp_data.pos_x !== exp_rsp.pos_x) begin
                  report_mismatch("pos_x", 32'(exp_rsp.pos_x), 32'(rsp_data.pos_x));
               end
               if (rsp_data.pos_y !== exp_rsp.pos_y) begin
                  report_mismatch("pos_y", 32'(exp_rsp.pos_y), 32'(rsp_data.pos_y));
               end
            end
         end
      end
   end

   // Hard stop in case the block stops moving
   initial begin
      #5_000_000;
      $display("tb NOT OK");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset values written back explicitly; disabled block first
      write_csr(ps2mq_pkg::CSR_ENABLE, 1'b0);
      write_csr(ps2mq_pkg::CSR_FLIP_Y, 1'b1);
      start_phase(25, 52);
      feed_item(8'h08);                       // ignored while disabled
      post_item(32767, -32768, 3'd7);         // post still works, both clamps
      pop_item(REQ_POP);
      pop_item(REQ_POP_ODD);                  // code three pops, ring now empty
      wait_idle();

      write_csr(ps2mq_pkg::CSR_ENABLE, 1'b1);
      start_phase(25, 52);
      feed_item(8'h00);                       // no sync bit: resync discard
      feed_item(8'h08); feed_item(8'h05); feed_item(8'h03);
      feed_item(8'h3F); feed_item(8'h00); feed_item(8'h00);   // both signs, -256
      feed_item(8'h28); feed_item(8'h00); feed_item(8'h01);   // dy -255 flipped
      feed_item(8'h48); feed_item(8'h01); feed_item(8'h01);   // x overflow
      feed_item(8'h88); feed_item(8'h02); feed_item(8'h02);   // y overflow
      post_item(-32768, 32767, 3'd0);         // drive x into the zero floor
      post_item(0, 0, 3'd0);
      pop_item(REQ_POP_ODD);
      pop_item(REQ_POP);
      wait_idle();

      // Sender idles lightly, receiver heavily; unflipped y
      write_csr(ps2mq_pkg::CSR_FLIP_Y, 1'b0);
      start_phase(25, 52);
      gen_traffic(160);
      wait_idle();

      // Roles swapped; flood the ring past full, then drain it past empty
      write_csr(ps2mq_pkg::CSR_FLIP_Y, 1'b1);
      start_phase(52, 25);
      gen_traffic(70);
      repeat (RING_SLOTS + 2) begin
         post_item(int'($urandom_range(32767, 127)), int'($urandom_range(32767, 127)),
                   3'($urandom_range(7)));
      end
      repeat (RING_SLOTS + 2) begin
         pop_item($urandom_range(1) == 1 ? REQ_POP_ODD : REQ_POP);
      end
      gen_traffic(70);
      wait_idle();

      // Disabled again: bytes drop, posts and pops still act
      write_csr(ps2mq_pkg::CSR_ENABLE, 1'b0);
      write_csr(ps2mq_pkg::CSR_FLIP_Y, 1'b0);
      start_phase(52, 25);
      gen_traffic(30);
      wait_idle();

      // No idling, with the long receiver hold-off at the start
      write_csr(ps2mq_pkg::CSR_ENABLE, 1'b1);
      write_csr(ps2mq_pkg::CSR_FLIP_Y, 1'b1);
      start_phase(0, 0);
      pressure_start = 1'b1;
      gen_traffic(120);
      wait_idle();

      // Let any stray result show up
      repeat (TAIL_CYCLES) @(negedge clock);
      if (accepted_cnt != queued_total || rsp_expect_q.size() != 0) begin
         report_mismatch("requests or results outstanding at end",
                         queued_total - accepted_cnt, rsp_expect_q.size());
      end

      $display("run covered %0d transfers: %0d queued, %0d ring full, %0d popped, %0d empty",
               accepted_cnt, stat_seen[ps2mq_pkg::STAT_QUEUED],
               stat_seen[ps2mq_pkg::STAT_FULL], stat_seen[ps2mq_pkg::STAT_POPPED],
               stat_seen[ps2mq_pkg::STAT_EMPTY]);
      $display("bytes: %0d stored, %0d ignored, %0d resync, %0d overflow drops; %0d errors",
               stat_seen[ps2mq_pkg::STAT_STORED], stat_seen[ps2mq_pkg::STAT_IGNORED],
               stat_seen[ps2mq_pkg::STAT_RESYNC], stat_seen[ps2mq_pkg::STAT_OVERFLOW],
               err_count);
      if (err_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
